// ----- src/phd_pkg.sv -----
// ----------------------------------------------------------------------------
// phd_pkg
// Types and constants shared by the packet header deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package phd_pkg;

    // Header layout: byte positions in wire order
    localparam int unsigned HDR_BYTES = 21;
    localparam int unsigned POS_W     = 5;

    localparam logic [POS_W-1:0] HDR_LEN        = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] POS_VERSION    = 5'd0;
    localparam logic [POS_W-1:0] POS_FLAGS_LAST = 5'd2;
    localparam logic [POS_W-1:0] POS_MSGID_LAST = 5'd4;
    localparam logic [POS_W-1:0] POS_SEQ_LAST   = 5'd8;
    localparam logic [POS_W-1:0] POS_SESS_LAST  = 5'd16;

    localparam logic [31:0] MAX_LEN_RESET = 32'd65535;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_OVER     = 2'd2,
        ST_MISMATCH = 2'd3
    } t_status;

    // One result word
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        byte_valid;
        logic        packet_done;
        t_status     status;
        logic [7:0]  version;
        logic [15:0] flags;
        logic [15:0] msg_ident;
        logic [31:0] sequence_res;
        logic [63:0] session_id;
        logic [31:0] declared_length;
    } t_result;

endpackage

`default_nettype wire

// ----- src/phd_parse.sv -----
// ----------------------------------------------------------------------------
// phd_parse
// Header field shift registers, header position and payload byte counter;
// forms the result word for the byte at its input.
// ----------------------------------------------------------------------------
`default_nettype none

module phd_parse import phd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_packet,
    input  wire logic [31:0] i_max_len,
    output t_result          o_res,
    output logic             o_res_valid
);

    logic [POS_W-1:0] r_pos,     n_pos;
    logic [7:0]       r_version, n_version;
    logic [15:0]      r_flags,   n_flags;
    logic [15:0]      r_msgid,   n_msgid;
    logic [31:0]      r_seq,     n_seq;
    logic [63:0]      r_sess,    n_sess;
    logic [31:0]      r_len,     n_len;
    logic [31:0]      r_cnt,     n_cnt;
    logic             is_payload;
    t_status          status;

    // Shift header bytes in, or count payload bytes
    always_comb begin
        n_pos      = r_pos;
        n_version  = r_version;
        n_flags    = r_flags;
        n_msgid    = r_msgid;
        n_seq      = r_seq;
        n_sess     = r_sess;
        n_len      = r_len;
        n_cnt      = r_cnt;
        is_payload = 1'b0;
        if (r_pos < HDR_LEN) begin
            priority if (r_pos == POS_VERSION) begin
                n_version = i_data_byte;
            end else if (r_pos <= POS_FLAGS_LAST) begin
                n_flags = {r_flags[7:0], i_data_byte};
            end else if (r_pos <= POS_MSGID_LAST) begin
                n_msgid = {r_msgid[7:0], i_data_byte};
            end else if (r_pos <= POS_SEQ_LAST) begin
                n_seq = {r_seq[23:0], i_data_byte};
            end else if (r_pos <= POS_SESS_LAST) begin
                n_sess = {r_sess[55:0], i_data_byte};
            end else begin
                n_len = {r_len[23:0], i_data_byte};
            end
            n_pos = r_pos + 5'd1;
        end else begin
            is_payload = 1'b1;
            if (r_cnt != '1) begin
                n_cnt = r_cnt + 32'd1;
            end
        end
    end

    // Check the finished datagram in priority order
    always_comb begin
        priority if (n_pos < HDR_LEN) begin
            status = ST_TRUNC;
        end else if (n_len > i_max_len) begin
            status = ST_OVER;
        end else if (n_cnt != n_len) begin
            status = ST_MISMATCH;
        end else begin
            status = ST_OK;
        end
    end

    // Form the result word; zero every field that does not apply
    always_comb begin
        o_res = '0;
        if (is_payload) begin
            o_res.payload_byte = i_data_byte;
            o_res.byte_valid   = 1'b1;
        end
        if (i_end_of_packet) begin
            o_res.packet_done = 1'b1;
            o_res.status      = status;
            if (status != ST_TRUNC) begin
                o_res.version         = n_version;
                o_res.flags           = n_flags;
                o_res.msg_ident       = n_msgid;
                o_res.sequence_res    = n_seq;
                o_res.session_id      = n_sess;
                o_res.declared_length = n_len;
            end
        end
    end

    assign o_res_valid = is_payload | i_end_of_packet;

    // Advance state; clear everything after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_end_of_packet)) begin
            r_pos     <= '0;
            r_version <= '0;
            r_flags   <= '0;
            r_msgid   <= '0;
            r_seq     <= '0;
            r_sess    <= '0;
            r_len     <= '0;
            r_cnt     <= '0;
        end else if (i_take) begin
            r_pos     <= n_pos;
            r_version <= n_version;
            r_flags   <= n_flags;
            r_msgid   <= n_msgid;
            r_seq     <= n_seq;
            r_sess    <= n_sess;
            r_len     <= n_len;
            r_cnt     <= n_cnt;
        end
    end

    // Header position never runs past the header length
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= HDR_LEN)
        else $error("header position beyond header length");

    // Payload is counted only once the header is complete
    a_cnt_after_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) |-> (r_pos == HDR_LEN))
        else $error("payload counted before header complete");

    // The last byte always returns the block to the start of a header
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_end_of_packet) |=> (r_pos == '0 && r_cnt == '0))
        else $error("state not cleared after last byte");

endmodule

`default_nettype wire

// ----- src/packet_header_deframer.sv -----
// ----------------------------------------------------------------------------
// packet_header_deframer
// Parses a 21-byte big-endian header from a byte stream and streams the
// remaining bytes out as payload, with a status on the last byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one datagram byte per word (i_data_byte) with
//   i_end_of_packet on its last byte; taken when i_in_valid is high and
//   o_in_stall is low.
//   Output channel: one word per payload byte and one on the last byte
//   (o_packet_done, with o_status and the header fields); taken when
//   o_out_valid is high and i_out_stall is low. Header bytes that are not
//   last produce no word. Drop the payload of a datagram whose status is
//   not ok.
//   Config channel: i_cfg_data sets max_payload_length, always ready; write
//   it only while no datagram is in flight.
//   Output words come from the single result register; throughput is one
//   byte per cycle while i_out_stall is low.
//   While a result waits and i_out_stall is high, the input is stalled.
//   Reset clears the parser state and output valid, and loads the limit
//   with 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_header_deframer import phd_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input byte channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_packet,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_payload_byte,
    output logic             o_byte_valid,
    output logic             o_packet_done,
    output logic [1:0]       o_status,
    output logic [7:0]       o_version,
    output logic [15:0]      o_flags,
    output logic [15:0]      o_message_id,
    output logic [31:0]      o_sequence_res,
    output logic [63:0]      o_session_id,
    output logic [31:0]      o_declared_length,
    // configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);

    logic [31:0] r_max_len;
    t_result     r_out;
    logic        r_out_valid;
    t_result     res;
    logic        res_valid;
    logic        take;

    // Hold input while a result waits on a stalled receiver
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign take        = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    phd_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_data_byte     (i_data_byte),
        .i_end_of_packet (i_end_of_packet),
        .i_max_len       (r_max_len),
        .o_res           (res),
        .o_res_valid     (res_valid)
    );

    // Limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_payload_byte    = r_out.payload_byte;
    assign o_byte_valid      = r_out.byte_valid;
    assign o_packet_done     = r_out.packet_done;
    assign o_status          = r_out.status;
    assign o_version         = r_out.version;
    assign o_flags           = r_out.flags;
    assign o_message_id      = r_out.msg_ident;
    assign o_sequence_res    = r_out.sequence_res;
    assign o_session_id      = r_out.session_id;
    assign o_declared_length = r_out.declared_length;

    // Every result carries a payload byte, a done flag, or both
    a_res_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_byte_valid || o_packet_done))
        else $error("result with neither payload nor done");

    // A truncated datagram reports no header fields
    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_packet_done && o_status == ST_TRUNC)
            |-> (o_declared_length == '0 && o_session_id == '0 && o_version == '0))
        else $error("header fields reported on truncated datagram");

    // Input is never stalled while the result register is empty
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

    // A payload word without done never carries a status
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_packet_done) |-> (o_status == ST_OK))
        else $error("status set on a word that is not last");

endmodule

`default_nettype wire

// ----- bench/packet_header_deframer_tb.sv -----
// ----------------------------------------------------------------------------
// packet_header_deframer_tb
// Self-checking bench for the packet header deframer. A byte stream of
// datagrams is sent in random bursts while the result side stalls on its own
// pattern. A local parser tracks the header, the payload count and the limit,
// and works out every expected result word, which is then compared field by
// field with what the block emits. Directed datagrams cover the header
// extremes, each status and the limit extremes. Random traffic follows.
// ----------------------------------------------------------------------------
module packet_header_deframer_tb;
    import phd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    localparam int unsigned RANDOM_BYTES = 840;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte     = 8'd0;
    logic        i_end_of_packet = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall     = 1'b0;
    logic [7:0]  o_payload_byte;
    logic        o_byte_valid;
    logic        o_packet_done;
    logic [1:0]  o_status;
    logic [7:0]  o_version;
    logic [15:0] o_flags;
    logic [15:0] o_message_id;
    logic [31:0] o_sequence_res;
    logic [63:0] o_session_id;
    logic [31:0] o_declared_length;
    logic        i_cfg_valid     = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data      = 32'd0;

    // Parser state mirrored from the block
    logic [4:0]  hdr_pos     = '0;
    logic [7:0]  version_acc = '0;
    logic [15:0] flags_acc   = '0;
    logic [15:0] msgid_acc   = '0;
    logic [31:0] seq_acc     = '0;
    logic [63:0] session_acc = '0;
    logic [31:0] length_acc  = '0;
    logic [31:0] payload_cnt = '0;
    logic [31:0] limit_now   = MAX_LEN_RESET;

    t_result     expected_words[$];
    int unsigned error_count  = 0;
    int unsigned words_seen   = 0;
    int unsigned bytes_sent   = 0;
    int unsigned burst_left   = 0;
    int unsigned status_seen[4];

    t_stall_mode stall_mode   = STALL_NONE;
    int unsigned stall_left   = 0;
    int unsigned stall_phase  = 0;

    packet_header_deframer i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_data_byte       (i_data_byte),
        .i_end_of_packet   (i_end_of_packet),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_payload_byte    (o_payload_byte),
        .o_byte_valid      (o_byte_valid),
        .o_packet_done     (o_packet_done),
        .o_status          (o_status),
        .o_version         (o_version),
        .o_flags           (o_flags),
        .o_message_id      (o_message_id),
        .o_sequence_res    (o_sequence_res),
        .o_session_id      (o_session_id),
        .o_declared_length (o_declared_length),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Bail out if the run hangs
    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            log_error($sformatf("word %0d: %s got 0x%0h want 0x%0h",
                                words_seen, name, got, want));
        end
    endtask

    // Advance the parser by one accepted byte and queue the word it causes
    task automatic parse_byte(input logic [7:0] b, input logic eop);
        t_result want;
        logic    is_payload;
        is_payload = (hdr_pos >= HDR_LEN);
        if (!is_payload) begin
            if (hdr_pos == POS_VERSION) begin
                version_acc = b;
            end else if (hdr_pos <= POS_FLAGS_LAST) begin
                flags_acc = {flags_acc[7:0], b};
            end else if (hdr_pos <= POS_MSGID_LAST) begin
                msgid_acc = {msgid_acc[7:0], b};
            end else if (hdr_pos <= POS_SEQ_LAST) begin
                seq_acc = {seq_acc[23:0], b};
            end else if (hdr_pos <= POS_SESS_LAST) begin
                session_acc = {session_acc[55:0], b};
            end else begin
                length_acc = {length_acc[23:0], b};
            end
            hdr_pos = hdr_pos + 5'd1;
        end else if (payload_cnt != '1) begin
            payload_cnt = payload_cnt + 32'd1;
        end
        if (is_payload || eop) begin
            want = '0;
            if (is_payload) begin
                want.payload_byte = b;
                want.byte_valid   = 1'b1;
            end
            if (eop) begin
                want.packet_done = 1'b1;
                if (hdr_pos < HDR_LEN) begin
                    want.status = ST_TRUNC;
                end else if (length_acc > limit_now) begin
                    want.status = ST_OVER;
                end else if (payload_cnt != length_acc) begin
                    want.status = ST_MISMATCH;
                end else begin
                    want.status = ST_OK;
                end
                if (want.status != ST_TRUNC) begin
                    want.version         = version_acc;
                    want.flags           = flags_acc;
                    want.msg_ident       = msgid_acc;
                    want.sequence_res    = seq_acc;
                    want.session_id      = session_acc;
                    want.declared_length = length_acc;
                end
                // Start over for the next datagram
                hdr_pos     = '0;
                version_acc = '0;
                flags_acc   = '0;
                msgid_acc   = '0;
                seq_acc     = '0;
                session_acc = '0;
                length_acc  = '0;
                payload_cnt = '0;
            end
            expected_words.insert(expected_words.size(), want);
        end
    endtask

    // Check result words first, then predict from the accepted input word
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    log_error($sformatf("word %0d arrived with none expected", words_seen));
                end else begin
                    want = expected_words.pop_front();
                    check_field("payload_byte", 64'(o_payload_byte),
                                64'(want.payload_byte));
                    check_field("byte_valid", 64'(o_byte_valid), 64'(want.byte_valid));
                    check_field("packet_done", 64'(o_packet_done),
                                64'(want.packet_done));
                    check_field("status", 64'(o_status), 64'(want.status));
                    check_field("version", 64'(o_version), 64'(want.version));
                    check_field("flags", 64'(o_flags), 64'(want.flags));
                    check_field("msg_ident", 64'(o_message_id), 64'(want.msg_ident));
                    check_field("sequence_res", 64'(o_sequence_res),
                                64'(want.sequence_res));
                    check_field("session_id", o_session_id, want.session_id);
                    check_field("declared_length", 64'(o_declared_length),
                                64'(want.declared_length));
                    if (want.packet_done) begin
                        status_seen[want.status]++;
                    end
                end
                words_seen++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                limit_now = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                parse_byte(i_data_byte, i_end_of_packet);
            end
        end
    end

    // Result-side back pressure: switch between stall patterns now and then
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end else begin
            stall_left--;
        end
        stall_phase++;
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 9) < 8);
            default:        i_out_stall <= (stall_phase % 5 < 2);
        endcase
    end

    // Send one word, with a random gap whenever a burst runs out
    task automatic send_byte(input logic [7:0] b, input logic eop);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_data_byte     <= b;
        i_end_of_packet <= eop;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [167:0] make_header(
        input logic [7:0]  ver,
        input logic [15:0] flg,
        input logic [15:0] mid,
        input logic [31:0] seq,
        input logic [63:0] sid,
        input logic [31:0] len
    );
        return {ver, flg, mid, seq, sid, len};
    endfunction

    function automatic logic [167:0] random_header(input logic [31:0] len);
        return make_header(8'($urandom), 16'($urandom), 16'($urandom), $urandom,
                           {$urandom, $urandom}, len);
    endfunction

    // Send header then payload; a nonzero keep cuts the datagram short
    task automatic send_datagram(input logic [167:0] hdr, input int unsigned n_payload,
                                 input int unsigned keep);
        int unsigned total;
        logic [7:0]  b;
        total = HDR_BYTES + n_payload;
        if (keep != 0 && keep < total) begin
            total = keep;
        end
        for (int unsigned i = 0; i < total; i++) begin
            b = (i < HDR_BYTES) ? hdr[167 - 8 * i -: 8] : 8'($urandom);
            send_byte(b, i == total - 1);
        end
    endtask

    // Reset limit sits exactly at the over-limit boundary
    task automatic test_default_limit;
        send_datagram(random_header(32'd65535), 0, 0);
        send_datagram(random_header(32'd65536), 0, 0);
        send_datagram(random_header(32'd2), 2, 0);
        drain();
    endtask

    task automatic test_header_extremes;
        send_datagram('0, 0, 0);
        send_datagram('1, 1, 0);
        send_datagram({21{8'hA5}} & make_header('1, '1, '1, '1, '1, 32'd0), 0, 0);
        send_datagram(make_header(8'h5A, 16'h55AA, 16'hAA55, 32'h0F0F_F0F0,
                                  64'h0123_4567_89AB_CDEF, 32'd1), 1, 0);
        drain();
    endtask

    // Datagrams that end inside the header
    task automatic test_truncated;
        send_datagram(random_header(32'd0), 0, 1);
        send_datagram(random_header(32'd0), 0, 2);
        send_datagram(random_header(32'd0), 0, HDR_BYTES - 1);
        drain();
    endtask

    task automatic test_payload_status;
        send_datagram(random_header(32'd3), 3, 0);
        send_datagram(random_header(32'd3), 2, 0);
        send_datagram(random_header(32'd2), 5, 0);
        send_datagram(random_header(32'd1), 1, 0);
        drain();
    endtask

    task automatic test_limit_extremes;
        write_limit(32'd0);
        send_datagram(random_header(32'd0), 0, 0);
        send_datagram(random_header(32'd1), 1, 0);
        write_limit('1);
        send_datagram(random_header('1), 2, 0);
        send_datagram(random_header(32'd4), 4, 0);
        write_limit(32'd4);
        send_datagram(random_header(32'd4), 4, 0);
        send_datagram(random_header(32'd5), 5, 0);
        drain();
    endtask

    // Mostly well-formed datagrams with random content, plus broken ones
    task automatic test_random_traffic;
        int unsigned start_bytes;
        int unsigned next_cfg;
        int unsigned kind;
        int unsigned n_payload;
        logic [31:0] limit_pick;
        start_bytes = bytes_sent;
        next_cfg    = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES) begin
            if (bytes_sent >= next_cfg) begin
                case ($urandom_range(0, 4))
                    0:       limit_pick = 32'($urandom_range(0, 24));
                    1:       limit_pick = MAX_LEN_RESET;
                    2:       limit_pick = '1;
                    3:       limit_pick = 32'd0;
                    default: limit_pick = $urandom;
                endcase
                write_limit(limit_pick);
                next_cfg = bytes_sent + $urandom_range(100, 250);
            end
            kind      = $urandom_range(0, 99);
            n_payload = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64)
                                                     : $urandom_range(0, 16);
            if (kind < 70) begin
                send_datagram(random_header(n_payload), n_payload, 0);
            end else if (kind < 80) begin
                send_datagram(random_header(n_payload + $urandom_range(1, 3)),
                              n_payload, 0);
            end else if (kind < 90) begin
                send_datagram(random_header($urandom), 0, $urandom_range(1, HDR_BYTES - 1));
            end else begin
                send_datagram(random_header($urandom), n_payload, 0);
            end
        end
        drain();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_limit();
        test_header_extremes();
        test_truncated();
        test_payload_status();
        test_limit_extremes();
        test_random_traffic();

        repeat (8) @(posedge i_clk);
        $display("Sent %0d bytes, checked %0d result words", bytes_sent, words_seen);
        $display("Datagrams by status: ok %0d, truncated %0d, over limit %0d, mismatch %0d",
                 status_seen[ST_OK], status_seen[ST_TRUNC], status_seen[ST_OVER],
                 status_seen[ST_MISMATCH]);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
